@@ hdl/gas_pkg.sv @@
package gas_pkg;

  localparam int FIELD_ID_W = 16;

  localparam logic [2:0] REQ_ADD_VERTEX    = 3'd0;
  localparam logic [2:0] REQ_ADD_EDGE      = 3'd1;
  localparam logic [2:0] REQ_REMOVE_EDGE   = 3'd2;
  localparam logic [2:0] REQ_REMOVE_VERTEX = 3'd3;
  localparam logic [2:0] REQ_QUERY_EDGE    = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_VERTEX  = 3'd1;
  localparam logic [2:0] ST_PRESENT    = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_NO_EDGE    = 3'd4;

  typedef struct packed {
    logic [2:0]            req_type;
    logic [FIELD_ID_W-1:0] vertex_a;
    logic [FIELD_ID_W-1:0] vertex_b;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       edge_present;
  } rsp_t;

endpackage

@@ hdl/gas_lookup.sv @@
module gas_lookup
  import gas_pkg::*;
#(
  parameter int MAX_VERTICES = 16,
  parameter int ID_WIDTH     = 16
) (
  input  logic [ID_WIDTH-1:0]     id_a,
  input  logic [ID_WIDTH-1:0]     id_b,
  input  logic [MAX_VERTICES-1:0] slot_valid,
  input  logic [ID_WIDTH-1:0]     slot_id [MAX_VERTICES],
  output logic                    a_hit,
  output logic [MAX_VERTICES-1:0] a_sel,
  output logic                    b_hit,
  output logic [MAX_VERTICES-1:0] b_sel,
  output logic                    free_hit,
  output logic [MAX_VERTICES-1:0] free_sel
);

  logic [MAX_VERTICES-1:0] a_match;
  logic [MAX_VERTICES-1:0] b_match;
  logic [MAX_VERTICES-1:0] free_slots;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      a_match[i] = slot_valid[i] && (slot_id[i] == id_a);
      b_match[i] = slot_valid[i] && (slot_id[i] == id_b);
    end
  end

  assign free_slots = ~slot_valid;

  // lowest set bit wins
  assign a_sel    = a_match & (~a_match + MAX_VERTICES'(1));
  assign b_sel    = b_match & (~b_match + MAX_VERTICES'(1));
  assign free_sel = free_slots & (~free_slots + MAX_VERTICES'(1));

  assign a_hit    = |a_match;
  assign b_hit    = |b_match;
  assign free_hit = |free_slots;

endmodule

@@ hdl/gas_store.sv @@
module gas_store
  import gas_pkg::*;
#(
  parameter int MAX_VERTICES = 16,
  parameter int ID_WIDTH     = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic commit,
  input  req_t req,
  output rsp_t rsp
);

  logic [MAX_VERTICES-1:0] slot_valid;
  logic [MAX_VERTICES-1:0] slot_valid_next;
  logic [ID_WIDTH-1:0]     slot_id [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] rows [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] rows_next [MAX_VERTICES];

  logic [ID_WIDTH-1:0]     id_a;
  logic [ID_WIDTH-1:0]     id_b;
  logic                    a_hit;
  logic                    b_hit;
  logic                    free_hit;
  logic [MAX_VERTICES-1:0] a_sel;
  logic [MAX_VERTICES-1:0] b_sel;
  logic [MAX_VERTICES-1:0] free_sel;

  logic                    both_hit;
  logic                    edge_bit;
  logic                    do_add;
  logic                    do_remove;
  logic                    do_set_edge;
  logic                    do_clr_edge;
  logic [MAX_VERTICES-1:0] wipe_sel;

  assign id_a = ID_WIDTH'(req.vertex_a);
  assign id_b = ID_WIDTH'(req.vertex_b);

  gas_lookup #(
    .MAX_VERTICES(MAX_VERTICES),
    .ID_WIDTH    (ID_WIDTH)
  ) u_lookup (
    .id_a      (id_a),
    .id_b      (id_b),
    .slot_valid(slot_valid),
    .slot_id   (slot_id),
    .a_hit     (a_hit),
    .a_sel     (a_sel),
    .b_hit     (b_hit),
    .b_sel     (b_sel),
    .free_hit  (free_hit),
    .free_sel  (free_sel)
  );

  assign both_hit = a_hit && b_hit;

  always_comb begin
    edge_bit = 1'b0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      edge_bit = edge_bit | (a_sel[i] & (|(rows[i] & b_sel)));
    end
  end

  assign do_add      = commit && (req.req_type == REQ_ADD_VERTEX) && !a_hit && free_hit;
  assign do_remove   = commit && (req.req_type == REQ_REMOVE_VERTEX) && a_hit;
  assign do_set_edge = commit && (req.req_type == REQ_ADD_EDGE) && both_hit;
  assign do_clr_edge = commit && (req.req_type == REQ_REMOVE_EDGE) && both_hit;

  // slot whose row and column are wiped
  assign wipe_sel = do_add ? free_sel : (do_remove ? a_sel : '0);

  always_comb begin
    slot_valid_next = slot_valid;
    if (do_add) begin
      slot_valid_next = slot_valid | free_sel;
    end else if (do_remove) begin
      slot_valid_next = slot_valid & ~a_sel;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      rows_next[i] = rows[i] & ~wipe_sel;
      if (do_clr_edge && a_sel[i]) begin
        rows_next[i] = rows_next[i] & ~b_sel;
      end
      if (do_set_edge && a_sel[i]) begin
        rows_next[i] = rows_next[i] | b_sel;
      end
      if (wipe_sel[i]) begin
        rows_next[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        rows[i] <= '0;
      end
    end else begin
      slot_valid <= slot_valid_next;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        rows[i] <= rows_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (do_add && free_sel[i]) begin
        slot_id[i] <= id_a;
      end
    end
  end

  always_comb begin
    rsp.status       = ST_OK;
    rsp.edge_present = 1'b0;
    unique case (req.req_type)
      REQ_ADD_VERTEX: begin
        if (a_hit) begin
          rsp.status = ST_PRESENT;
        end else if (!free_hit) begin
          rsp.status = ST_FULL;
        end
      end
      REQ_ADD_EDGE: begin
        if (both_hit) begin
          rsp.edge_present = 1'b1;
        end else begin
          rsp.status = ST_NO_VERTEX;
        end
      end
      REQ_REMOVE_EDGE: begin
        if (!both_hit) begin
          rsp.status = ST_NO_VERTEX;
        end else if (!edge_bit) begin
          rsp.status = ST_NO_EDGE;
        end
      end
      REQ_QUERY_EDGE: begin
        if (!both_hit) begin
          rsp.status = ST_NO_VERTEX;
        end else if (edge_bit) begin
          rsp.edge_present = 1'b1;
        end else begin
          rsp.status = ST_NO_EDGE;
        end
      end
      REQ_REMOVE_VERTEX: begin
        if (!a_hit) begin
          rsp.status = ST_NO_VERTEX;
        end
      end
      default: begin
        rsp.status = ST_OK;
      end
    endcase
  end

endmodule

@@ hdl/graph_adjacency_store_core.sv @@
// Directed graph store: MAX_VERTICES vertex slots, each with an id and a
// row of adjacency bits.
// Request channel (req_valid/req_ready/req): one transaction per request
// (add vertex, add edge, remove edge, remove vertex, query edge).
// Response channel (rsp_valid/rsp_ready/rsp): exactly one transaction per
// request, in request order, carrying status and edge_present.
// A request is held in the input register, and its response is then registered
// in the response register. Throughput: one request per cycle when the receiver
// does not stall; all slot compares and the row/column update for a request are
// done in the same cycle, with the slot id compare feeding the row update.
// The graph state changes only as a request moves from the input register
// into the response register, so later requests see its effect.
// When rsp_ready is low the response is held; the input register still takes
// one more request, after which req_ready drops until the response drains.
// Reset (rst, synchronous) empties the table and all edges and drops any
// request or response in flight; no clearing pass is needed.
module graph_adjacency_store_core
  import gas_pkg::*;
#(
  parameter int MAX_VERTICES = 16,
  parameter int ID_WIDTH     = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic s_valid;
  req_t s_req;
  logic o_load;
  rsp_t rsp_next;

  assign o_load    = s_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !rst && (!s_valid || o_load);

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (req_ready) begin
      s_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s_req <= req;
    end
  end

  gas_store #(
    .MAX_VERTICES(MAX_VERTICES),
    .ID_WIDTH    (ID_WIDTH)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .commit(o_load),
    .req   (s_req),
    .rsp   (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (o_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      rsp <= rsp_next;
    end
  end

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    s_valid && !o_load |=> s_valid && $stable(s_req))
    else $error("pending request lost or changed");

  a_present_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.edge_present |-> rsp.status == ST_OK)
    else $error("edge_present with non-ok status");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status == ST_OK || rsp.status == ST_NO_VERTEX ||
                  rsp.status == ST_PRESENT || rsp.status == ST_FULL ||
                  rsp.status == ST_NO_EDGE)
    else $error("status code out of range");

endmodule
